[design/touch_button_led_effect_channel_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the touch button LED effect channel
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TOUCH_BUTTON_LED_EFFECT_CHANNEL_ASSERT_SVH
`define TOUCH_BUTTON_LED_EFFECT_CHANNEL_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TBLED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define TBLED_ASSERT_NEVER(label, cond, msg) \
    `TBLED_ASSERT(label, !(cond), msg)

`endif

[design/tbled_pkg.sv]
// ---------------------------------------------------------------------------
// tbled_pkg
// Shared types, register codes, reset values and tables of the touch
// button LED effect channel.
// ---------------------------------------------------------------------------
`default_nettype none

package tbled_pkg;

    localparam int DEFAULT_CHANNELS = 5;
    localparam int REG_CHANNELS     = 5;

    localparam int CH_W    = 3;
    localparam int COUNT_W = 25;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 8;
    localparam int BMODE_W = 2;
    localparam int LMODE_W = 6;
    localparam int DIM_W   = 7;
    localparam int CFG_W   = 40;
    localparam int PERIOD_W = 11;

    // x / 100 == (x * 5243) >> 19 for x <= 255 * 100
    localparam int DIM_RECIP = 5243;
    localparam int DIM_SHIFT = 19;
    localparam int FAC_W     = 20;
    localparam int DIM_MAX   = 100;

    localparam logic [CFG_W-1:0] THRESH_RESET = 40'hC8_C8_C8_C8_C8;
    localparam logic [CFG_W-1:0] BRIGHT_RESET = 40'h64_64_1E_FF_2D;

    typedef enum logic [CH_W-1:0] {
        REG_BUTTON_MODES = 3'd0,
        REG_LED_MODES    = 3'd1,
        REG_LED_ON_BITS  = 3'd2,
        REG_THRESHOLDS   = 3'd3,
        REG_MAX_BRIGHT   = 3'd4,
        REG_DIM_PERCENTS = 3'd5
    } cfg_reg_t;

    typedef logic [BMODE_W-1:0] bmode_t;
    typedef logic [LMODE_W-1:0] lmode_t;

    localparam bmode_t BTN_OFF       = 2'd0;
    localparam bmode_t BTN_MOMENTARY = 2'd1;
    localparam bmode_t BTN_TOGGLE    = 2'd2;

    localparam lmode_t LED_OFF      = 6'd0;
    localparam lmode_t LED_SOLID    = 6'd1;
    localparam lmode_t LED_FLASH_LO = 6'd20;
    localparam lmode_t LED_FLASH_HI = 6'd29;
    localparam lmode_t LED_PULSE_LO = 6'd30;
    localparam lmode_t LED_PULSE_HI = 6'd39;

    function automatic logic [PERIOD_W-1:0] rate_period(input logic [3:0] idx);
        logic [PERIOD_W-1:0] p;
        case (idx)
            4'd0:    p = 11'd1500;
            4'd1:    p = 11'd1250;
            4'd2:    p = 11'd1000;
            4'd3:    p = 11'd750;
            4'd4:    p = 11'd500;
            4'd5:    p = 11'd350;
            4'd6:    p = 11'd250;
            4'd7:    p = 11'd150;
            4'd8:    p = 11'd100;
            4'd9:    p = 11'd50;
            default: p = 11'd0;
        endcase
        return p;
    endfunction

    // dim percent, saturated to 100, times the reciprocal of 100
    function automatic logic [FAC_W-1:0] dim_factor(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] ds;
        ds = (d > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : d;
        return FAC_W'(ds) * FAC_W'(DIM_RECIP);
    endfunction

endpackage

`default_nettype wire

[design/touch_button_led_effect_channel.sv]
// ---------------------------------------------------------------------------
// touch_button_led_effect_channel
// Touch button debounce-free press logic and LED effect per channel.
// ---------------------------------------------------------------------------
// One item is taken every clock cycle while in_stall is low. An item waits in
// the input register, where the selected channel's state is read, updated and
// written back in the same cycle, and its result is then registered in the
// result register.
// A stall on the output holds both registers; the input then stalls only
// while both are full.
// Configuration writes take effect at the edge they are written on.
`default_nettype none

module touch_button_led_effect_channel #(
    parameter int CHANNELS = tbled_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [tbled_pkg::CH_W-1:0]        cfg_index,
    input  wire logic [tbled_pkg::CFG_W-1:0]       cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [tbled_pkg::CH_W-1:0]        channel,
    input  wire logic signed [tbled_pkg::COUNT_W-1:0] sensor_count,
    input  wire logic [tbled_pkg::TIME_W-1:0]      now_ms,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tbled_pkg::CH_W-1:0]             out_channel,
    output logic [tbled_pkg::LEVEL_W-1:0]          pwm_level,
    output logic                                   pwm_written,
    output logic                                   button_status
);

    import tbled_pkg::*;

    // configuration
    logic [BMODE_W*REG_CHANNELS-1:0] button_modes_reg;
    logic [LMODE_W*REG_CHANNELS-1:0] led_modes_reg;
    logic [REG_CHANNELS-1:0]         led_on_bits_reg;
    logic [CFG_W-1:0]                thresholds_reg;
    logic [CFG_W-1:0]                max_bright_reg;
    logic [FAC_W-1:0]                dim_fac_reg [REG_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_modes_reg <= '0;
            led_modes_reg    <= '0;
            led_on_bits_reg  <= '0;
            thresholds_reg   <= THRESH_RESET;
            max_bright_reg   <= BRIGHT_RESET;
            for (int i = 0; i < REG_CHANNELS; i++)
            begin
                dim_fac_reg[i] <= dim_factor(DIM_W'(DIM_MAX));
            end
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BUTTON_MODES: button_modes_reg <= cfg_data[BMODE_W*REG_CHANNELS-1:0];
                REG_LED_MODES:    led_modes_reg    <= cfg_data[LMODE_W*REG_CHANNELS-1:0];
                REG_LED_ON_BITS:  led_on_bits_reg  <= cfg_data[REG_CHANNELS-1:0];
                REG_THRESHOLDS:   thresholds_reg   <= cfg_data;
                REG_MAX_BRIGHT:   max_bright_reg   <= cfg_data;
                REG_DIM_PERCENTS:
                begin
                    for (int i = 0; i < REG_CHANNELS; i++)
                    begin
                        dim_fac_reg[i] <= dim_factor(cfg_data[DIM_W*i +: DIM_W]);
                    end
                end
                default: ;
            endcase
        end
    end

    // per-channel register fields; channels past the register widths read zero
    bmode_t             bm_lane   [CHANNELS];
    lmode_t             lm_lane   [CHANNELS];
    logic               on_lane   [CHANNELS];
    logic [LEVEL_W-1:0] thr_lane  [CHANNELS];
    logic [LEVEL_W-1:0] full_lane [CHANNELS];
    logic [FAC_W-1:0]   fac_lane  [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        if (c < REG_CHANNELS)
        begin : g_reg
            assign bm_lane[c]   = button_modes_reg[BMODE_W*c +: BMODE_W];
            assign lm_lane[c]   = led_modes_reg[LMODE_W*c +: LMODE_W];
            assign on_lane[c]   = led_on_bits_reg[c];
            assign thr_lane[c]  = thresholds_reg[LEVEL_W*c +: LEVEL_W];
            assign full_lane[c] = max_bright_reg[LEVEL_W*c +: LEVEL_W];
            assign fac_lane[c]  = dim_fac_reg[c];
        end
        else
        begin : g_zero
            assign bm_lane[c]   = BTN_OFF;
            assign lm_lane[c]   = LED_OFF;
            assign on_lane[c]   = 1'b0;
            assign thr_lane[c]  = '0;
            assign full_lane[c] = '0;
            assign fac_lane[c]  = '0;
        end
    end

    // handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic s1_adv;

    assign in_stall       = s1_valid_reg & out_valid_reg & out_stall;
    assign in_accept      = in_valid & ~in_stall;
    assign s1_adv         = s1_valid_reg & ~(out_valid_reg & out_stall);
    assign s1_valid_next  = in_accept | (s1_valid_reg & ~s1_adv);
    assign out_valid_next = s1_adv | (out_valid_reg & out_stall);

    // input register
    logic [CH_W-1:0]           s1_channel_reg;
    logic signed [COUNT_W-1:0] s1_count_reg;
    logic [TIME_W-1:0]         s1_now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_channel_reg <= channel;
            s1_count_reg   <= sensor_count;
            s1_now_reg     <= now_ms;
        end
    end

    // channel state
    logic               pressed_reg    [CHANNELS];
    logic               press_seen_reg [CHANNELS];
    logic               status_reg     [CHANNELS];
    logic [LEVEL_W-1:0] led_value_reg  [CHANNELS];
    logic [TIME_W-1:0]  next_time_reg  [CHANNELS];

    // selected channel
    logic               ch_ok;
    logic [CHANNELS-1:0] hit;
    bmode_t             bm_s;
    lmode_t             lm_s;
    logic               on_s;
    logic [LEVEL_W-1:0] thr_s;
    logic [LEVEL_W-1:0] full_s;
    logic [FAC_W-1:0]   fac_s;
    logic               p_s;
    logic               ps_s;
    logic               st_s;
    logic [LEVEL_W-1:0] lv_s;
    logic [TIME_W-1:0]  nt_s;

    assign ch_ok = {1'b0, s1_channel_reg} < (CH_W+1)'(CHANNELS);

    always_comb
    begin
        hit    = '0;
        bm_s   = BTN_OFF;
        lm_s   = LED_OFF;
        on_s   = 1'b0;
        thr_s  = '0;
        full_s = '0;
        fac_s  = '0;
        p_s    = 1'b0;
        ps_s   = 1'b0;
        st_s   = 1'b0;
        lv_s   = '0;
        nt_s   = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (s1_channel_reg == CH_W'(c))
            begin
                hit[c] = 1'b1;
                bm_s   = bm_lane[c];
                lm_s   = lm_lane[c];
                on_s   = on_lane[c];
                thr_s  = thr_lane[c];
                full_s = full_lane[c];
                fac_s  = fac_lane[c];
                p_s    = pressed_reg[c];
                ps_s   = press_seen_reg[c];
                st_s   = status_reg[c];
                lv_s   = led_value_reg[c];
                nt_s   = next_time_reg[c];
            end
        end
    end

    // button
    logic                      any_button;
    logic signed [COUNT_W-1:0] thr_signed;
    logic                      p_next;
    logic                      ps_next;
    logic                      st_next;

    // only the channels that exist enable the press logic
    always_comb
    begin
        any_button = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (bm_lane[c] != BTN_OFF)
            begin
                any_button = 1'b1;
            end
        end
    end

    assign thr_signed = signed'({{(COUNT_W-LEVEL_W){1'b0}}, thr_s});

    always_comb
    begin
        p_next  = p_s;
        ps_next = ps_s;
        st_next = st_s;
        if (any_button)
        begin
            if (s1_count_reg > thr_signed)
            begin
                p_next = 1'b1;
            end
            else if (s1_count_reg < thr_signed)
            begin
                p_next = 1'b0;
            end
            if (bm_s == BTN_MOMENTARY)
            begin
                st_next = p_next;
            end
            else if (bm_s == BTN_TOGGLE)
            begin
                if (p_next && !ps_s)
                begin
                    ps_next = 1'b1;
                    st_next = ~st_s;
                end
                else if (!p_next && ps_s)
                begin
                    ps_next = 1'b0;
                end
            end
        end
    end

    // LED
    logic                is_flash;
    logic                is_pulse;
    lmode_t              rate_sel;
    logic [PERIOD_W-1:0] period;
    logic                due;
    logic [TIME_W-1:0]   nt_reload;
    logic [LEVEL_W-1:0]  lv_next;
    logic [TIME_W-1:0]   nt_next;

    assign is_flash  = lm_s inside {[LED_FLASH_LO:LED_FLASH_HI]};
    assign is_pulse  = lm_s inside {[LED_PULSE_LO:LED_PULSE_HI]};
    assign rate_sel  = is_flash ? (lm_s - LED_FLASH_LO) : (lm_s - LED_PULSE_LO);
    assign period    = rate_period(rate_sel[3:0]);
    assign due       = nt_s <= s1_now_reg;
    assign nt_reload = s1_now_reg + TIME_W'(period);

    always_comb
    begin
        lv_next = lv_s;
        nt_next = nt_s;
        if (lm_s == LED_SOLID)
        begin
            lv_next = on_s ? full_s : '0;
        end
        else if (is_flash)
        begin
            if (!on_s)
            begin
                lv_next = '0;
            end
            if (st_next && due)
            begin
                lv_next = (lv_next == full_s) ? '0 : full_s;
                nt_next = nt_reload;
            end
        end
        else if (is_pulse)
        begin
            if (!on_s)
            begin
                lv_next = '0;
            end
            else if (due)
            begin
                lv_next = (lv_s != '0) ? '0 : full_s;
                nt_next = nt_reload;
            end
        end
    end

    // dimmed level
    logic [LEVEL_W+FAC_W-1:0] dim_prod;
    logic                     led_active;

    assign dim_prod   = (LEVEL_W+FAC_W)'(lv_next) * (LEVEL_W+FAC_W)'(fac_s);
    assign led_active = lm_s != LED_OFF;

    // state write-back
    logic upd;

    assign upd = s1_adv & ch_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                pressed_reg[c]    <= 1'b0;
                press_seen_reg[c] <= 1'b0;
                status_reg[c]     <= 1'b0;
                led_value_reg[c]  <= '0;
                next_time_reg[c]  <= '0;
            end
        end
        else if (upd)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (hit[c])
                begin
                    pressed_reg[c]    <= p_next;
                    press_seen_reg[c] <= ps_next;
                    status_reg[c]     <= st_next;
                    if (led_active)
                    begin
                        led_value_reg[c] <= lv_next;
                        next_time_reg[c] <= nt_next;
                    end
                end
            end
        end
    end

    // result register
    logic [CH_W-1:0]    out_channel_reg;
    logic [LEVEL_W-1:0] pwm_level_reg;
    logic               pwm_written_reg;
    logic               status_out_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_channel_reg <= s1_channel_reg;
            pwm_level_reg   <= (ch_ok && led_active)
                             ? dim_prod[DIM_SHIFT +: LEVEL_W] : '0;
            pwm_written_reg <= ch_ok & led_active;
            status_out_reg  <= ch_ok & st_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign pwm_level     = pwm_level_reg;
    assign pwm_written   = pwm_written_reg;
    assign button_status = status_out_reg;

endmodule

`default_nettype wire

[design/tbled_checker.sv]
// ---------------------------------------------------------------------------
// tbled_checker
// Port-level checks of the touch button LED effect channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "touch_button_led_effect_channel_assert.svh"

module tbled_checker #(
    parameter int CHANNELS = tbled_pkg::DEFAULT_CHANNELS
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic [tbled_pkg::CH_W-1:0]           out_channel,
    input wire logic [tbled_pkg::LEVEL_W-1:0]        pwm_level,
    input wire logic                                 pwm_written,
    input wire logic                                 button_status
);

    import tbled_pkg::*;

    logic bad_channel;

    assign bad_channel = {1'b0, out_channel} >= (CH_W+1)'(CHANNELS);

    // input backs up only behind a full, stalled result
    `TBLED_ASSERT(a_in_stall_cause, in_stall |-> (out_valid && out_stall),
        "input stalled without a stalled result")

    // a channel past the last one yields an empty result
    `TBLED_ASSERT(a_bad_channel_empty,
        (out_valid && bad_channel) |-> (!pwm_written && !button_status && pwm_level == '0),
        "result for a missing channel is not empty")

    // an undriven pin carries no level
    `TBLED_ASSERT_NEVER(a_level_unwritten, out_valid && !pwm_written && pwm_level != '0,
        "pwm level without pwm written")

    `TBLED_ASSERT(a_out_hold,
        (out_valid && out_stall) |=> (out_valid && $stable(out_channel)
            && $stable(pwm_level) && $stable(pwm_written) && $stable(button_status)),
        "stalled result changed")

endmodule

bind touch_button_led_effect_channel tbled_checker #(
    .CHANNELS (CHANNELS)
) u_tbled_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .pwm_level     (pwm_level),
    .pwm_written   (pwm_written),
    .button_status (button_status)
);

`default_nettype wire
